/* src/dsp_pkg.sv */
package dsp_pkg;

	localparam int DIST_W    = 16;
	localparam int NODE_W    = 3;
	localparam int NCFG_W    = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_NUM_NODES = 2'd0;
	localparam cfg_idx_t REG_INFINITY  = 2'd1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_RUN   = 1'b1;

	localparam logic [NCFG_W-1:0] NUM_NODES_RST = 4'd5;
	localparam logic [DIST_W-1:0] INFINITY_RST  = 16'd9999;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_PICK,
		ST_RELAX,
		ST_OUT
	} state_t;

endpackage

/* src/dsp_ram.sv */
module dsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/dijkstra_shortest_paths_core.sv */
// Channel   Handshake              Payload
// request   start / busy           req_type, row_node, col_node, edge_weight, source_node
// config    cfg_we                 cfg_index, cfg_data
// result    result_strobe          node_index, distance, reachable, last
//
// An edge write is taken while idle and busy stays low. A run over n nodes first seeds
// the distance memory, then runs up to n-1 rounds of a scan (one distance read per cycle),
// a pick and a relax pass (adjacency and distance read together; skipped after an
// unreachable pick), then streams the results. After reset all MAX_NODES*MAX_NODES
// adjacency entries are zeroed one entry a cycle with busy high. Results come one per
// cycle and the receiver cannot stall.
module dijkstra_shortest_paths_core #(
	parameter int MAX_NODES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [2:0]                     row_node,
	input  logic [2:0]                     col_node,
	input  logic [15:0]                    edge_weight,
	input  logic [2:0]                     source_node,
	input  logic                           cfg_we,
	input  logic [dsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	output logic                           result_strobe,
	output logic [2:0]                     node_index,
	output logic [15:0]                    distance,
	output logic                           reachable,
	output logic                           last
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
	localparam int DW    = dsp_pkg::DIST_W;
	localparam int NW    = dsp_pkg::NODE_W;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_NODES * MAX_NODES - 1);

	dsp_pkg::state_t state_q, state_d;

	logic [dsp_pkg::NCFG_W-1:0] num_nodes_q;
	logic [DW-1:0]              inf_q;
	logic [CNT_W-1:0]           n_eff;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           rnd_q;
	logic [AW-1:0]              clr_q;
	logic [2:0]                 src_q;
	logic                       vld_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [DW-1:0]              best_q;
	logic [IDX_W-1:0]           pick_q;
	logic                       found_q;
	logic [MAX_NODES-1:0]       visited_q;

	logic                       accept;
	logic                       issue;
	logic                       drain_done;
	logic                       src_ok;
	logic                       last_round;
	logic [DW:0]                sum;
	logic                       relax_hit;
	logic                       scan_hit;

	logic                       dist_we;
	logic [IDX_W-1:0]           dist_waddr;
	logic [DW-1:0]              dist_wdata;
	logic [IDX_W-1:0]           dist_raddr;
	logic [DW-1:0]              dist_rdata;
	logic                       adj_we;
	logic [AW-1:0]              adj_waddr;
	logic [DW-1:0]              adj_wdata;
	logic [AW-1:0]              adj_raddr;
	logic [DW-1:0]              adj_rdata;

	logic                       res_strobe_q;
	logic [NW-1:0]              res_index_q;
	logic [DW-1:0]              res_dist_q;
	logic                       res_reach_q;
	logic                       res_last_q;

	assign busy   = (state_q != dsp_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign n_eff = (int'(num_nodes_q) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(num_nodes_q);

	assign issue      = (cnt_q < n_eff);
	assign drain_done = !issue && !vld_s1;
	assign src_ok     = (int'(src_q) < int'(n_eff));
	assign last_round = (int'(rnd_q) + 2 >= int'(n_eff));

	assign sum = {1'b0, best_q} + {1'b0, adj_rdata};

	assign relax_hit = (state_q == dsp_pkg::ST_RELAX) && vld_s1 && !visited_q[idx_s1] &&
		(adj_rdata != '0) && (sum < {1'b0, dist_rdata});

	// Ties go to the later index, hence the less-or-equal.
	assign scan_hit = (state_q == dsp_pkg::ST_SCAN) && vld_s1 && !visited_q[idx_s1] &&
		(dist_rdata <= best_q);

	dsp_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_NODES * MAX_NODES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dsp_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_NODES)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsp_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = dsp_pkg::ST_IDLE;
				end
			end
			dsp_pkg::ST_IDLE: begin
				if (accept && (req_type == dsp_pkg::REQ_RUN) && (n_eff != '0)) begin
					state_d = dsp_pkg::ST_INIT;
				end
			end
			dsp_pkg::ST_INIT: begin
				if (int'(cnt_q) + 1 == int'(n_eff)) begin
					state_d = (src_ok && int'(n_eff) >= 2) ? dsp_pkg::ST_SCAN : dsp_pkg::ST_OUT;
				end
			end
			dsp_pkg::ST_SCAN: begin
				if (drain_done) begin
					state_d = dsp_pkg::ST_PICK;
				end
			end
			dsp_pkg::ST_PICK: begin
				if (!found_q) begin
					state_d = dsp_pkg::ST_OUT;
				end else if (best_q == inf_q) begin
					// An unreachable pick relaxes nothing; the round ends here.
					state_d = last_round ? dsp_pkg::ST_OUT : dsp_pkg::ST_SCAN;
				end else begin
					state_d = dsp_pkg::ST_RELAX;
				end
			end
			dsp_pkg::ST_RELAX: begin
				if (drain_done) begin
					state_d = last_round ? dsp_pkg::ST_OUT : dsp_pkg::ST_SCAN;
				end
			end
			dsp_pkg::ST_OUT: begin
				if (drain_done) begin
					state_d = dsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		adj_we     = 1'b0;
		adj_waddr  = AW'(int'(row_node) * MAX_NODES + int'(col_node));
		adj_wdata  = edge_weight;
		adj_raddr  = AW'(int'(pick_q) * MAX_NODES + int'(cnt_q));
		dist_we    = 1'b0;
		dist_waddr = cnt_q[IDX_W-1:0];
		dist_wdata = inf_q;
		dist_raddr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			dsp_pkg::ST_CLEAR: begin
				adj_we    = 1'b1;
				adj_waddr = clr_q;
				adj_wdata = '0;
			end
			dsp_pkg::ST_IDLE: begin
				adj_we = accept && (req_type == dsp_pkg::REQ_WRITE) &&
					(int'(row_node) < MAX_NODES) && (int'(col_node) < MAX_NODES);
			end
			dsp_pkg::ST_INIT: begin
				dist_we = 1'b1;
				if (src_ok && (int'(cnt_q) == int'(src_q))) begin
					dist_wdata = '0;
				end
			end
			dsp_pkg::ST_RELAX: begin
				dist_we    = relax_hit;
				dist_waddr = idx_s1;
				dist_wdata = sum[DW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dsp_pkg::ST_CLEAR;
			num_nodes_q  <= dsp_pkg::NUM_NODES_RST;
			inf_q        <= dsp_pkg::INFINITY_RST;
			clr_q        <= '0;
			cnt_q        <= '0;
			rnd_q        <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			visited_q    <= '0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					dsp_pkg::REG_NUM_NODES: num_nodes_q <= cfg_data[dsp_pkg::NCFG_W-1:0];
					dsp_pkg::REG_INFINITY:  inf_q       <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == dsp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			if (state_q != state_d) begin
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
			end else begin
				case (state_q)
					dsp_pkg::ST_INIT: begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					dsp_pkg::ST_SCAN, dsp_pkg::ST_RELAX, dsp_pkg::ST_OUT: begin
						vld_s1 <= issue;
						if (issue) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end

			if ((state_q == dsp_pkg::ST_IDLE) && (state_d == dsp_pkg::ST_INIT)) begin
				rnd_q     <= '0;
				visited_q <= '0;
			end

			if ((state_d == dsp_pkg::ST_SCAN) && (state_q != dsp_pkg::ST_SCAN)) begin
				found_q <= 1'b0;
				if ((state_q == dsp_pkg::ST_PICK) || (state_q == dsp_pkg::ST_RELAX)) begin
					rnd_q <= rnd_q + CNT_W'(1);
				end
			end else if (scan_hit) begin
				found_q <= 1'b1;
			end

			if ((state_q == dsp_pkg::ST_PICK) && found_q) begin
				visited_q[pick_q] <= 1'b1;
			end

			res_strobe_q <= (state_q == dsp_pkg::ST_OUT) && vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dsp_pkg::ST_IDLE) begin
			src_q <= source_node;
		end
		if ((state_q != state_d) || (state_q == dsp_pkg::ST_INIT)) begin
			idx_s1 <= idx_s1;
		end else begin
			idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if ((state_d == dsp_pkg::ST_SCAN) && (state_q != dsp_pkg::ST_SCAN)) begin
			best_q <= inf_q;
		end else if (scan_hit) begin
			best_q <= dist_rdata;
			pick_q <= idx_s1;
		end
		if ((state_q == dsp_pkg::ST_OUT) && vld_s1) begin
			res_index_q <= NW'(idx_s1);
			res_dist_q  <= dist_rdata;
			res_reach_q <= (dist_rdata < inf_q);
			res_last_q  <= (int'(idx_s1) + 1 == int'(n_eff));
		end
	end

	assign result_strobe = res_strobe_q;
	assign node_index    = res_index_q;
	assign distance      = res_dist_q;
	assign reachable     = res_reach_q;
	assign last          = res_last_q;

endmodule

/* src/dsp_checker.sv */
module dsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [2:0] node_index,
	input logic       last
);

	// A result beat only appears while a run is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result beat while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> busy && result_strobe)
		else $error("run stopped before its last result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !busy && !result_strobe)
		else $error("block still busy after the last result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && $past(result_strobe) && !$past(last) |->
			node_index == 3'($past(node_index) + 3'd1))
		else $error("result beats out of node order");

	// No new request can be taken while results are being streamed.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !(start && !busy))
		else $error("request accepted during a run");

endmodule

bind dijkstra_shortest_paths_core dsp_checker u_dsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.node_index    (node_index),
	.last          (last)
);

/* tb/tb_dijkstra_shortest_paths_core.sv */
`timescale 1ns / 1ps

module tb_dijkstra_shortest_paths_core;

	localparam int MAX_NODES     = 8;
	localparam int SETTLE_CYCLES = 200;

	localparam dsp_pkg::cfg_idx_t REG_UNUSED_LO = 2'd2;
	localparam dsp_pkg::cfg_idx_t REG_UNUSED_HI = 2'd3;

	typedef struct packed {
		logic                       req;
		logic [dsp_pkg::NODE_W-1:0] row;
		logic [dsp_pkg::NODE_W-1:0] col;
		logic [dsp_pkg::DIST_W-1:0] weight;
		logic [dsp_pkg::NODE_W-1:0] src;
	} path_request_t;

	typedef struct packed {
		logic [dsp_pkg::NODE_W-1:0] node;
		logic [dsp_pkg::DIST_W-1:0] dist_val;
		logic                       reach;
		logic                       is_last;
	} node_report_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              req_type = 1'b0;
	logic [2:0]        row_node = '0;
	logic [2:0]        col_node = '0;
	logic [15:0]       edge_weight = '0;
	logic [2:0]        source_node = '0;
	logic              cfg_we = 1'b0;
	dsp_pkg::cfg_idx_t cfg_index = dsp_pkg::REG_NUM_NODES;
	logic [15:0]       cfg_data = '0;
	logic              result_strobe;
	logic [2:0]        node_index;
	logic [15:0]       distance;
	logic              reachable;
	logic              last;

	// Model state kept alongside the block.
	logic [dsp_pkg::NCFG_W-1:0] cfg_nodes = dsp_pkg::NUM_NODES_RST;
	logic [dsp_pkg::DIST_W-1:0] cfg_infinity = dsp_pkg::INFINITY_RST;
	logic [dsp_pkg::DIST_W-1:0] edge_w [MAX_NODES][MAX_NODES];

	path_request_t     pending_requests[$];
	node_report_t      expected_reports[$];
	path_request_t     head;
	node_report_t      seen;
	node_report_t      want;
	int                idle_pct = 0;
	int                mismatch_count = 0;
	int                runs_taken = 0;
	int                writes_taken = 0;
	int                reports_checked = 0;
	int                reachable_seen = 0;

	int                phase_nodes [7] = '{8, 3, 8, 6, 2, 8, 7};
	int                phase_inf   [7] = '{9999, 50, 65535, 200, 1, 1000, 30000};
	int                phase_idle  [7] = '{0, 71, 6, 71, 0, 6, 71};

	dijkstra_shortest_paths_core #(.MAX_NODES(MAX_NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.row_node(row_node),
		.col_node(col_node),
		.edge_weight(edge_weight),
		.source_node(source_node),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.node_index(node_index),
		.distance(distance),
		.reachable(reachable),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Run timed out with %0d requests queued and %0d reports outstanding.",
			pending_requests.size(), expected_reports.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic compute_shortest_paths(input logic [dsp_pkg::NODE_W-1:0] src);
		logic [dsp_pkg::DIST_W-1:0] dist_a [MAX_NODES];
		logic                       done [MAX_NODES];
		logic [dsp_pkg::DIST_W:0]   sum;
		logic [dsp_pkg::DIST_W-1:0] best;
		int                         n, pick, rnd, v;
		bit                         found;
		node_report_t               rep;
		n = (int'(cfg_nodes) > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);
		for (v = 0; v < MAX_NODES; v++) begin
			dist_a[v] = cfg_infinity;
			done[v] = 1'b0;
		end
		if (int'(src) < n) begin
			dist_a[src] = '0;
			for (rnd = 0; rnd + 1 < n; rnd++) begin
				best = cfg_infinity;
				pick = 0;
				found = 1'b0;
				// Ties go to the highest index, hence the less-or-equal.
				for (v = 0; v < n; v++) begin
					if (!done[v] && dist_a[v] <= best) begin
						best = dist_a[v];
						pick = v;
						found = 1'b1;
					end
				end
				if (!found)
					break;
				done[pick] = 1'b1;
				if (dist_a[pick] != cfg_infinity) begin
					for (v = 0; v < n; v++) begin
						sum = {1'b0, dist_a[pick]} + {1'b0, edge_w[pick][v]};
						if (!done[v] && edge_w[pick][v] != 0 && sum < {1'b0, dist_a[v]})
							dist_a[v] = sum[dsp_pkg::DIST_W-1:0];
					end
				end
			end
		end
		for (v = 0; v < n; v++) begin
			rep.node = dsp_pkg::NODE_W'(v);
			rep.dist_val = dist_a[v];
			rep.reach = dist_a[v] < cfg_infinity;
			rep.is_last = (v + 1 == n);
			expected_reports.push_back(rep);
		end
	endtask

	task automatic apply_request(input path_request_t r);
		if (r.req == dsp_pkg::REQ_WRITE) begin
			edge_w[r.row][r.col] = r.weight;
			writes_taken++;
		end else begin
			compute_shortest_paths(r.src);
			runs_taken++;
		end
	endtask

	task automatic flag_report(input string why, input node_report_t exp_r,
			input node_report_t got_r);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected node %0d dist %0d reach %0b last %0b, %s",
				$realtime, why, exp_r.node, exp_r.dist_val, exp_r.reach, exp_r.is_last,
				$sformatf("got node %0d dist %0d reach %0b last %0b",
					got_r.node, got_r.dist_val, got_r.reach, got_r.is_last));
	endtask

	// Request driver: holds a beat until the block takes it, then offers the next.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start)
				apply_request(pending_requests.pop_front());
			if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
				head = pending_requests[0];
				start <= 1'b1;
				req_type <= head.req;
				row_node <= head.row;
				col_node <= head.col;
				edge_weight <= head.weight;
				source_node <= head.src;
			end else begin
				start <= 1'b0;
				req_type <= 1'($urandom_range(1));
				row_node <= 3'($urandom_range(7));
				col_node <= 3'($urandom_range(7));
				edge_weight <= 16'($urandom_range(16'hFFFF));
				source_node <= 3'($urandom_range(7));
			end
		end
	end

	// Result monitor: every strobed beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			seen.node = node_index;
			seen.dist_val = distance;
			seen.reach = reachable;
			seen.is_last = last;
			if (expected_reports.size() == 0) begin
				flag_report("result with nothing expected", '0, seen);
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				if (want.reach)
					reachable_seen++;
				if (seen.node !== want.node || seen.dist_val !== want.dist_val
						|| seen.reach !== want.reach || seen.is_last !== want.is_last)
					flag_report("node report mismatch", want, seen);
			end
		end
	end

	task automatic write_reg(input dsp_pkg::cfg_idx_t idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == dsp_pkg::REG_NUM_NODES)
			cfg_nodes = data[dsp_pkg::NCFG_W-1:0];
		else if (idx == dsp_pkg::REG_INFINITY)
			cfg_infinity = data;
	endtask

	task automatic queue_edge(input int row, input int col, input logic [15:0] w);
		path_request_t r;
		r.req = dsp_pkg::REQ_WRITE;
		r.row = dsp_pkg::NODE_W'(row);
		r.col = dsp_pkg::NODE_W'(col);
		r.weight = w;
		r.src = dsp_pkg::NODE_W'($urandom_range(7));
		pending_requests.push_back(r);
	endtask

	task automatic queue_run(input int src);
		path_request_t r;
		r.req = dsp_pkg::REQ_RUN;
		r.row = dsp_pkg::NODE_W'($urandom_range(7));
		r.col = dsp_pkg::NODE_W'($urandom_range(7));
		r.weight = dsp_pkg::DIST_W'($urandom_range(16'hFFFF));
		r.src = dsp_pkg::NODE_W'(src);
		pending_requests.push_back(r);
	endtask

	// Returns once the block has taken every request and reported every run.
	task automatic settle();
		while (pending_requests.size() != 0)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic fill_random(input int count);
		int          n_use, lim, k, pick;
		logic [15:0] w;
		n_use = (int'(cfg_nodes) > MAX_NODES) ? MAX_NODES : int'(cfg_nodes);
		lim = (int'(cfg_infinity) / 4 > 1) ? int'(cfg_infinity) / 4 : 1;
		@(negedge clk);
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 22) begin
				if (n_use > 0 && $urandom_range(99) < 85)
					queue_run(int'($urandom_range(n_use - 1)));
				else
					queue_run(int'($urandom_range(7)));
			end else begin
				pick = int'($urandom_range(99));
				if (pick < 10)
					w = '0;
				else if (pick < 20)
					w = 16'($urandom_range(16'hFFFF));
				else if (pick < 28)
					w = 16'(int'(cfg_infinity) - int'($urandom_range(3)));
				else
					w = 16'($urandom_range(lim, 1));
				if (n_use > 0 && $urandom_range(99) < 85)
					queue_edge(int'($urandom_range(n_use - 1)),
						int'($urandom_range(n_use - 1)), w);
				else
					queue_edge(int'($urandom_range(7)), int'($urandom_range(7)), w);
			end
		end
	endtask

	initial begin
		int p;
		for (int r = 0; r < MAX_NODES; r++)
			for (int c = 0; c < MAX_NODES; c++)
				edge_w[r][c] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// The adjacency memory is cleared after reset with busy high.
		do @(posedge clk); while (busy !== 1'b0);

		// Reset settings: five nodes, infinity at its default.
		@(negedge clk);
		queue_run(0);
		queue_run(7);
		queue_edge(0, 1, 3);
		queue_edge(1, 2, 4);
		queue_edge(0, 2, 7);
		queue_edge(2, 3, 1);
		queue_edge(3, 4, 9000);
		queue_edge(1, 4, 16'hFFFF);
		queue_edge(4, 0, 2);
		queue_edge(7, 7, 16'hFFFF);
		queue_edge(2, 2, 5);
		queue_run(0);
		queue_run(4);
		queue_run(5);
		queue_edge(0, 2, 0);
		// A path that lands one below infinity, then exactly on it.
		queue_edge(3, 4, 9990);
		queue_run(0);
		queue_edge(3, 4, 9991);
		queue_run(0);
		settle();

		write_reg(dsp_pkg::REG_INFINITY, 16'd0);
		@(negedge clk);
		queue_run(0);
		settle();

		write_reg(dsp_pkg::REG_NUM_NODES, 16'hFFF0);
		@(negedge clk);
		queue_run(1);
		settle();

		// A node count above the maximum clamps to eight nodes.
		write_reg(dsp_pkg::REG_NUM_NODES, 16'h000F);
		write_reg(dsp_pkg::REG_INFINITY, 16'hFFFF);
		@(negedge clk);
		queue_edge(6, 7, 16'hFFFF);
		queue_edge(4, 7, 16'hFFFE);
		queue_run(4);
		settle();

		write_reg(dsp_pkg::REG_NUM_NODES, 16'd1);
		write_reg(dsp_pkg::REG_INFINITY, 16'd1);
		write_reg(REG_UNUSED_LO, 16'h0003);
		write_reg(REG_UNUSED_HI, 16'hFFFF);
		@(negedge clk);
		queue_run(0);
		queue_run(1);
		settle();

		for (p = 0; p < 7; p++) begin
			write_reg(dsp_pkg::REG_NUM_NODES,
				16'(($urandom_range(16'hFFFF) & 32'hFFF0) | 32'(phase_nodes[p])));
			write_reg(dsp_pkg::REG_INFINITY, 16'(phase_inf[p]));
			if (p == 3)
				write_reg(REG_UNUSED_HI, 16'($urandom_range(16'hFFFF)));
			idle_pct = phase_idle[p];
			fill_random(50);
			settle();
		end

		$display("Covered %0d shortest-path runs and %0d edge writes; %0d node reports checked,",
			runs_taken, writes_taken, reports_checked);
		$display("%0d of them reachable, over five directed settings and seven random ones.",
			reachable_seen);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
